[rtl/mbe_pkg.sv]
// shared constants, types and helper functions for the escape-time pixel core
// no dependencies; imported by every module of the block
package mbe_pkg;

    localparam int COORD_BITS = 10;
    localparam int FRAC_BITS  = 28;
    localparam int COUNT_BITS = 16;

    // q4.frac value width and the fixed register widths
    localparam int VAL_W      = FRAC_BITS + 4;
    localparam int ORIGIN_W   = 32;
    localparam int STEP_W     = 29;
    localparam int COLOUR_W   = 8;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;

    // derived datapath widths
    localparam int PROD_W  = COORD_BITS + STEP_W;
    localparam int SUM_W   = ((ORIGIN_W > PROD_W + 1) ? ORIGIN_W : PROD_W + 1) + 1;
    localparam int SQ_W    = 2 * VAL_W;
    localparam int WIDE_W  = (SQ_W + 2 > SUM_W) ? SQ_W + 2 : SUM_W;
    localparam int SCALE_W = COUNT_BITS + 4;
    localparam int SCALE_BYTES = (SCALE_W + 7) / 8;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int COLOUR_MOD = 255;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RE_ORIGIN = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_RE_STEP   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_IM_ORIGIN = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_IM_STEP   = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_ITER_LIM  = CFG_IDX_W'(4);

    // register reset values: -2.0, about 3/800, -1.5, about 3/800, 100
    localparam logic signed [ORIGIN_W-1:0] RST_RE_ORIGIN = ORIGIN_W'(-536870912);
    localparam logic [STEP_W-1:0]          RST_RE_STEP   = STEP_W'(1006633);
    localparam logic signed [ORIGIN_W-1:0] RST_IM_ORIGIN = ORIGIN_W'(-402653184);
    localparam logic [STEP_W-1:0]          RST_IM_STEP   = STEP_W'(1006633);
    localparam logic [COUNT_BITS-1:0]      RST_ITER_LIM  = COUNT_BITS'(100);

    // 4.0 in the scale of an exact square (2*FRAC_BITS fraction bits)
    localparam logic [SQ_W:0] FOUR_SQ = (SQ_W + 1)'(1) << (2 * FRAC_BITS + 2);

    typedef struct packed {
        logic [ORIGIN_W-1:0] re_origin;
        logic [STEP_W-1:0]   re_step;
        logic [ORIGIN_W-1:0] im_origin;
        logic [STEP_W-1:0]   im_step;
    } mbe_cfg_t;

    typedef struct packed {
        logic [VAL_W-1:0] cr;
        logic [VAL_W-1:0] ci;
    } c_point_t;

    // saturate a sign-extended wide value to the q4 range
    function automatic logic [VAL_W-1:0] sat_val(input logic [WIDE_W-1:0] v);
        logic hi_or;
        logic hi_and;
        hi_or  = |v[WIDE_W-2:VAL_W-1];
        hi_and = &v[WIDE_W-2:VAL_W-1];
        if (!v[WIDE_W-1] && hi_or)
            sat_val = {1'b0, {(VAL_W - 1){1'b1}}};
        else if (v[WIDE_W-1] && !hi_and)
            sat_val = {1'b1, {(VAL_W - 1){1'b0}}};
        else
            sat_val = v[VAL_W-1:0];
    endfunction

    // remainder by 255: 256 is 1 mod 255, so bytes are summed and folded
    function automatic logic [COLOUR_W-1:0] mod255(input logic [SCALE_W-1:0] a);
        logic [SCALE_BYTES*8-1:0] p;
        logic [11:0]              s;
        logic [8:0]               s2;
        logic [8:0]               s3;
        p = (SCALE_BYTES * 8)'(a);
        s = '0;
        for (int i = 0; i < SCALE_BYTES; i++)
        begin
            s = s + 12'(p[8*i +: 8]);
        end
        s2 = 9'(s[7:0]) + 9'(s[11:8]);
        s3 = 9'(s2[7:0]) + 9'(s2[8]);
        if (s3 >= 9'(COLOUR_MOD))
            s3 = s3 - 9'(COLOUR_MOD);
        mod255 = s3[COLOUR_W-1:0];
    endfunction

endpackage

[rtl/mbe_front.sv]
// front end: takes pixel coordinates and maps them to the point c
// depends on mbe_pkg; feeds mbe_queue
module mbe_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [mbe_pkg::COORD_BITS-1:0] pixel_x,
    input  logic [mbe_pkg::COORD_BITS-1:0] pixel_y,
    input  mbe_pkg::mbe_cfg_t           cfg,
    output logic                        push_valid,
    input  logic                        push_ready,
    output mbe_pkg::c_point_t           push_data
);
    import mbe_pkg::*;

    logic              prod_valid_reg;
    logic [PROD_W-1:0] re_prod_reg;
    logic [PROD_W-1:0] im_prod_reg;
    logic [WIDE_W-1:0] re_sum;
    logic [WIDE_W-1:0] im_sum;
    logic              accept;

    assign in_ready   = !prod_valid_reg || push_ready;
    assign accept     = in_valid && in_ready;
    assign push_valid = prod_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prod_valid_reg <= 1'b0;
        else if (accept)
            prod_valid_reg <= 1'b1;
        else if (push_ready)
            prod_valid_reg <= 1'b0;
    end

    // coordinate times step, registered before the add
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            re_prod_reg <= PROD_W'(pixel_x) * PROD_W'(cfg.re_step);
            im_prod_reg <= PROD_W'(pixel_y) * PROD_W'(cfg.im_step);
        end
    end

    always_comb
    begin
        re_sum = WIDE_W'($signed(cfg.re_origin)) + WIDE_W'({1'b0, re_prod_reg});
        im_sum = WIDE_W'($signed(cfg.im_origin)) + WIDE_W'({1'b0, im_prod_reg});
        push_data.cr = sat_val(re_sum);
        push_data.ci = sat_val(im_sum);
    end

endmodule

[rtl/mbe_queue.sv]
// short first-in first-out queue of points between front and iterator
// depends on mbe_pkg
module mbe_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  mbe_pkg::c_point_t push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output mbe_pkg::c_point_t pop_data
);
    import mbe_pkg::*;

    c_point_t          slot_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              push_fire;
    logic              pop_fire;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;
    assign pop_data   = slot_mem[rd_ptr_reg];

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        if (p == QPTR_W'(QUEUE_DEPTH - 1))
            ptr_inc = '0;
        else
            ptr_inc = p + QPTR_W'(1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push_fire)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (pop_fire)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (push_fire && !pop_fire)
                count_reg <= count_reg + QCNT_W'(1);
            else if (pop_fire && !push_fire)
                count_reg <= count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
            slot_mem[wr_ptr_reg] <= push_data;
    end

endmodule

[rtl/mbe_iter.sv]
// back end: iterates z = z*z + c for one point and holds the result
// depends on mbe_pkg; takes points from mbe_queue
module mbe_iter (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           pop_valid,
    output logic                           pop_ready,
    input  mbe_pkg::c_point_t              pop_data,
    input  logic [mbe_pkg::COUNT_BITS-1:0] limit,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [mbe_pkg::COUNT_BITS-1:0] iteration_count,
    output logic                           inside_set,
    output logic [mbe_pkg::COLOUR_W-1:0]   red,
    output logic [mbe_pkg::COLOUR_W-1:0]   green,
    output logic [mbe_pkg::COLOUR_W-1:0]   blue
);
    import mbe_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]               state_reg;
    logic [1:0]               state_next;
    logic [COUNT_BITS-1:0]    n_reg;
    logic                     out_valid_reg;

    logic signed [VAL_W-1:0]  zr_reg;
    logic signed [VAL_W-1:0]  zi_reg;
    logic signed [VAL_W-1:0]  cr_reg;
    logic signed [VAL_W-1:0]  ci_reg;
    logic signed [SQ_W-1:0]   p_rr_reg;
    logic signed [SQ_W-1:0]   p_ii_reg;
    logic signed [SQ_W-1:0]   p_ri_reg;

    logic [COUNT_BITS-1:0]    count_out_reg;
    logic                     inside_reg;
    logic [COLOUR_W-1:0]      red_reg;
    logic [COLOUR_W-1:0]      green_reg;
    logic [COLOUR_W-1:0]      blue_reg;

    logic [SQ_W:0]            sq_sum;
    logic                     below_four;
    logic                     go_on;
    logic signed [VAL_W-1:0]  rr;
    logic signed [VAL_W-1:0]  ii;
    logic signed [VAL_W-1:0]  ri2;
    logic signed [VAL_W-1:0]  zr_new;
    logic signed [VAL_W-1:0]  zi_new;
    logic                     out_free;
    logic                     inside_now;
    logic [SCALE_W-1:0]       scale5;
    logic [SCALE_W-1:0]       scale10;
    logic [SCALE_W-1:0]       scale15;

    assign pop_ready       = (state_reg == ST_IDLE);
    assign out_free        = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign iteration_count = count_out_reg;
    assign inside_set      = inside_reg;
    assign red             = red_reg;
    assign green           = green_reg;
    assign blue            = blue_reg;

    // escape test on the exact squares, then floored and saturated update
    always_comb
    begin
        sq_sum     = (SQ_W + 1)'($unsigned(p_rr_reg)) + (SQ_W + 1)'($unsigned(p_ii_reg));
        below_four = (sq_sum < FOUR_SQ);
        go_on      = (n_reg < limit) && below_four;
        rr         = sat_val(WIDE_W'(p_rr_reg >>> FRAC_BITS));
        ii         = sat_val(WIDE_W'(p_ii_reg >>> FRAC_BITS));
        ri2        = sat_val(WIDE_W'(p_ri_reg >>> (FRAC_BITS - 1)));
        zr_new     = sat_val(WIDE_W'(rr) - WIDE_W'(ii) + WIDE_W'(cr_reg));
        zi_new     = sat_val(WIDE_W'(ri2) + WIDE_W'(ci_reg));
        inside_now = (n_reg == limit);
        scale5     = (SCALE_W'(n_reg) << 2) + SCALE_W'(n_reg);
        scale10    = scale5 << 1;
        scale15    = (SCALE_W'(n_reg) << 4) - SCALE_W'(n_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop_valid)
                    state_next = ST_MUL;
            end
            ST_MUL:
                state_next = ST_UPD;
            ST_UPD:
            begin
                if (go_on)
                    state_next = ST_MUL;
                else
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_IDLE && pop_valid)
                n_reg <= '0;
            else if (state_reg == ST_UPD && go_on)
                n_reg <= n_reg + COUNT_BITS'(1);
            if (state_reg == ST_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && pop_valid)
        begin
            cr_reg <= pop_data.cr;
            ci_reg <= pop_data.ci;
            zr_reg <= '0;
            zi_reg <= '0;
        end
        if (state_reg == ST_MUL)
        begin
            p_rr_reg <= zr_reg * zr_reg;
            p_ii_reg <= zi_reg * zi_reg;
            p_ri_reg <= zr_reg * zi_reg;
        end
        if (state_reg == ST_UPD && go_on)
        begin
            zr_reg <= zr_new;
            zi_reg <= zi_new;
        end
        if (state_reg == ST_DONE && out_free)
        begin
            count_out_reg <= n_reg;
            inside_reg    <= inside_now;
            red_reg       <= inside_now ? '0 : mod255(scale5);
            green_reg     <= inside_now ? '0 : mod255(scale10);
            blue_reg      <= inside_now ? '0 : mod255(scale15);
        end
    end

`ifndef SYNTHESIS
    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> n_reg <= limit)
        else $error("iteration count ran past the limit");

    a_mul_then_upd: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MUL |=> state_reg == ST_UPD)
        else $error("product stage not followed by update");

    a_fresh_start: assert property (@(posedge clk) disable iff (!rst_n)
        pop_valid && pop_ready |=> n_reg == '0 && zr_reg == '0 && zi_reg == '0)
        else $error("new point did not start from zero");

    a_inside_black: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && inside_reg |-> red_reg == '0 && green_reg == '0 && blue_reg == '0)
        else $error("point inside the set is not black");

    a_zero_is_inside: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && count_out_reg == '0 |-> inside_reg)
        else $error("zero count reported outside the set");
`endif

endmodule

[rtl/mandelbrot_escape_time_pixel_core.sv]
// top level of the escape-time pixel core: register file and the three stages
// depends on mbe_pkg, mbe_front, mbe_queue and mbe_iter
//
// usage
//  - configuration: cfg_wr_en writes cfg_data to register cfg_index
//    (0 re_origin, 1 re_step, 2 im_origin, 3 im_step, 4 iteration_limit);
//    other indexes are ignored; write only while no pixel is in flight
//  - input channel: in_valid/in_ready transfer of pixel_x, pixel_y
//  - output channel: out_valid/out_ready transfer of iteration_count,
//    inside_set and the red, green, blue levels; one result per pixel, in order
//  - each iteration step runs on the shared three-multiplier loop
//    (products, then escape test and update); a pixel keeps the iterator
//    until its result enters the output register; that loop sets the sustained rate
//  - the front end and a two-entry queue keep taking pixels while the iterator
//    is busy, and the iterator starts the next pixel while a result waits
//  - a stalled receiver holds the result in the output register; once the
//    queue and front register are full, in_ready drops
//  - reset loads the default window (-2.0 - 1.5i, step about 3/800, limit 100)
//    and empties every stage; no clearing pass is needed
module mandelbrot_escape_time_pixel_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [mbe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mbe_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [mbe_pkg::COORD_BITS-1:0] pixel_x,
    input  logic [mbe_pkg::COORD_BITS-1:0] pixel_y,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [mbe_pkg::COUNT_BITS-1:0] iteration_count,
    output logic                           inside_set,
    output logic [mbe_pkg::COLOUR_W-1:0]   red,
    output logic [mbe_pkg::COLOUR_W-1:0]   green,
    output logic [mbe_pkg::COLOUR_W-1:0]   blue
);
    import mbe_pkg::*;

    // configuration registers
    logic [ORIGIN_W-1:0]   re_origin_reg;
    logic [STEP_W-1:0]     re_step_reg;
    logic [ORIGIN_W-1:0]   im_origin_reg;
    logic [STEP_W-1:0]     im_step_reg;
    logic [COUNT_BITS-1:0] iter_lim_reg;

    mbe_cfg_t window_cfg;

    // front to queue and queue to iterator
    logic     push_valid;
    logic     push_ready;
    c_point_t push_data;
    logic     pop_valid;
    logic     pop_ready;
    c_point_t pop_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            re_origin_reg <= RST_RE_ORIGIN;
            re_step_reg   <= RST_RE_STEP;
            im_origin_reg <= RST_IM_ORIGIN;
            im_step_reg   <= RST_IM_STEP;
            iter_lim_reg  <= RST_ITER_LIM;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_RE_ORIGIN: re_origin_reg <= cfg_data[ORIGIN_W-1:0];
                REG_RE_STEP:   re_step_reg   <= cfg_data[STEP_W-1:0];
                REG_IM_ORIGIN: im_origin_reg <= cfg_data[ORIGIN_W-1:0];
                REG_IM_STEP:   im_step_reg   <= cfg_data[STEP_W-1:0];
                REG_ITER_LIM:  iter_lim_reg  <= cfg_data[COUNT_BITS-1:0];
                default:       ; // unknown index, write dropped
            endcase
        end
    end

    assign window_cfg.re_origin = re_origin_reg;
    assign window_cfg.re_step   = re_step_reg;
    assign window_cfg.im_origin = im_origin_reg;
    assign window_cfg.im_step   = im_step_reg;

    // coordinate to point c, saturated to the q4 range
    mbe_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .cfg        (window_cfg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // decouples the front end from the long-running iterator
    mbe_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // escape-time loop, colour mapping and output register
    mbe_iter u_iter (
        .clk             (clk),
        .rst_n           (rst_n),
        .pop_valid       (pop_valid),
        .pop_ready       (pop_ready),
        .pop_data        (pop_data),
        .limit           (iter_lim_reg),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .iteration_count (iteration_count),
        .inside_set      (inside_set),
        .red             (red),
        .green           (green),
        .blue            (blue)
    );

endmodule
